// ===== design/llcp_pkg.sv =====
`default_nettype none
package llcp_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned DIFF_W    = COORD_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned DOT_W     = 64;
  localparam int unsigned WIDE_W    = 2 * DOT_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned NUM_W     = WIDE_W + FRAC_W;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned EPS_W     = 31;
  localparam int unsigned EPS_SHIFT = 40;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  // Per-item data that rides along with the arithmetic pipeline
  typedef struct packed {
    logic             ok;
    coord_t [2:0]     p1;
    coord_t [2:0]     p3;
    diff_t  [2:0]     d21;
    diff_t  [2:0]     d43;
    dot_t             d1343;
    dot_t             d4321;
    dot_t             d4343;
    coord_t           mua;
  } side_t;

  localparam coord_t SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage
`default_nettype wire

// ===== design/llcp_mul64.sv =====
`default_nettype none
module llcp_mul64 (
  input  logic                clk_i,
  input  llcp_pkg::dot_t      a_i,
  input  llcp_pkg::dot_t      b_i,
  output logic signed [127:0] p_o
);
  import llcp_pkg::*;

  localparam int unsigned HALF_W = DOT_W / 2;

  logic signed [DOT_W-1:0]  hh_q;
  logic signed [DOT_W:0]    hl_q;
  logic signed [DOT_W:0]    lh_q;
  logic        [DOT_W-1:0]  ll_q;
  logic signed [WIDE_W-1:0] p_q;

  logic signed [WIDE_W-1:0] hh_x, hl_x, lh_x;
  logic        [WIDE_W-1:0] ll_x;

  // Split each operand into a signed high half and an unsigned low half
  always_ff @(posedge clk_i) begin
    hh_q <= $signed(a_i[DOT_W-1:HALF_W]) * $signed(b_i[DOT_W-1:HALF_W]);
    hl_q <= $signed(a_i[DOT_W-1:HALF_W]) * $signed({1'b0, b_i[HALF_W-1:0]});
    lh_q <= $signed({1'b0, a_i[HALF_W-1:0]}) * $signed(b_i[DOT_W-1:HALF_W]);
    ll_q <= a_i[HALF_W-1:0] * b_i[HALF_W-1:0];
  end

  always_comb begin
    hh_x = WIDE_W'(hh_q);
    hl_x = WIDE_W'(hl_q);
    lh_x = WIDE_W'(lh_q);
    ll_x = WIDE_W'(ll_q);
  end

  always_ff @(posedge clk_i) begin
    p_q <= (hh_x <<< DOT_W) + (hl_x <<< HALF_W) + (lh_x <<< HALF_W) + $signed(ll_x);
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// ===== design/llcp_div.sv =====
`default_nettype none
module llcp_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic signed [143:0]   num_i,
  input  logic signed [127:0]   den_i,
  input  llcp_pkg::side_t       side_i,
  output logic                  valid_o,
  output llcp_pkg::coord_t      quot_o,
  output llcp_pkg::side_t       side_o
);
  import llcp_pkg::*;

  // absolute value stage
  logic              va_q;
  logic              nega_q;
  logic [NUM_W-1:0]  na_q;
  logic [WIDE_W-1:0] da_q;
  side_t             sa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nega_q <= num_i[NUM_W-1] ^ den_i[WIDE_W-1];
    na_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    da_q   <= den_i[WIDE_W-1] ? WIDE_W'(-den_i) : WIDE_W'(den_i);
    sa_q   <= side_i;
  end

  // one quotient bit per stage, MSB first
  logic              vld_q [0:QUO_W];
  logic              neg_q [0:QUO_W];
  logic              ovf_q [0:QUO_W];
  logic [WIDE_W-1:0] rem_q [0:QUO_W];
  logic [WIDE_W-1:0] den_q [0:QUO_W];
  logic [QUO_W-1:0]  low_q [0:QUO_W];
  logic [QUO_W-1:0]  quo_q [0:QUO_W];
  side_t             sd_q  [0:QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= va_q;
    end
  end

  // quotient of 2^32 or more saturates; flag it, else the remainder starts below the divisor
  always_ff @(posedge clk_i) begin
    neg_q[0] <= nega_q;
    ovf_q[0] <= WIDE_W'(na_q[NUM_W-1:QUO_W]) >= da_q;
    rem_q[0] <= WIDE_W'(na_q[NUM_W-1:QUO_W]);
    den_q[0] <= da_q;
    low_q[0] <= na_q[QUO_W-1:0];
    quo_q[0] <= '0;
    sd_q[0]  <= sa_q;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [WIDE_W:0] trial;
    logic [WIDE_W:0] diff;
    logic            take;

    always_comb begin
      trial = {rem_q[k], low_q[k][QUO_W-1]};
      diff  = trial - {1'b0, den_q[k]};
      take  = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[k+1] <= neg_q[k];
      ovf_q[k+1] <= ovf_q[k];
      rem_q[k+1] <= take ? diff[WIDE_W-1:0] : trial[WIDE_W-1:0];
      den_q[k+1] <= den_q[k];
      low_q[k+1] <= {low_q[k][QUO_W-2:0], 1'b0};
      quo_q[k+1] <= {quo_q[k][QUO_W-2:0], take};
      sd_q[k+1]  <= sd_q[k];
    end
  end

  // sign and saturate
  logic   vout_q;
  logic   negout_q;
  coord_t qout_q;
  side_t  sout_q;
  logic   big_pos, big_neg;

  always_comb begin
    big_pos = ovf_q[QUO_W] || quo_q[QUO_W][QUO_W-1];
    big_neg = ovf_q[QUO_W] || (quo_q[QUO_W] > {1'b1, {(QUO_W-1){1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    negout_q <= neg_q[QUO_W];
    sout_q   <= sd_q[QUO_W];
    if (neg_q[QUO_W]) begin
      qout_q <= big_neg ? SAT_MIN : coord_t'(-quo_q[QUO_W]);
    end else begin
      qout_q <= big_pos ? SAT_MAX : coord_t'(quo_q[QUO_W]);
    end
  end

  assign valid_o = vout_q;
  assign quot_o  = qout_q;
  assign side_o  = sout_q;

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[QUO_W] && !ovf_q[QUO_W] |-> rem_q[QUO_W] < den_q[QUO_W])
    else $error("remainder not below divisor");

  a_pos_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vout_q && !negout_q |-> !qout_q[QUO_W-1])
    else $error("positive quotient came out negative");

endmodule
`default_nettype wire

// ===== design/line_line_closest_points_unit.sv =====
// Throughput: one line pair per cycle; busy stays low, start may be held every cycle.
// The two 32-stage restoring dividers (one quotient bit per stage) set most of the latency.
// Results cannot be stalled by the receiver; each shows for one cycle with strobe_o.
// Reset (rst_ni low, asynchronous) drops every item in flight and clears epsilon to 0.
`default_nettype none
module line_line_closest_points_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [30:0]              cfg_data_i,
  input  llcp_pkg::coord_t         a_start_x_i,
  input  llcp_pkg::coord_t         a_start_y_i,
  input  llcp_pkg::coord_t         a_start_z_i,
  input  llcp_pkg::coord_t         a_end_x_i,
  input  llcp_pkg::coord_t         a_end_y_i,
  input  llcp_pkg::coord_t         a_end_z_i,
  input  llcp_pkg::coord_t         b_start_x_i,
  input  llcp_pkg::coord_t         b_start_y_i,
  input  llcp_pkg::coord_t         b_start_z_i,
  input  llcp_pkg::coord_t         b_end_x_i,
  input  llcp_pkg::coord_t         b_end_y_i,
  input  llcp_pkg::coord_t         b_end_z_i,
  output logic                     strobe_o,
  output logic                     solution_ok_o,
  output llcp_pkg::coord_t         param_a_o,
  output llcp_pkg::coord_t         param_b_o,
  output llcp_pkg::coord_t         near_a_x_o,
  output llcp_pkg::coord_t         near_a_y_o,
  output llcp_pkg::coord_t         near_a_z_o,
  output llcp_pkg::coord_t         near_b_x_o,
  output llcp_pkg::coord_t         near_b_y_o,
  output llcp_pkg::coord_t         near_b_z_o
);
  import llcp_pkg::*;

  localparam int unsigned DOT_1343 = 0;
  localparam int unsigned DOT_4321 = 1;
  localparam int unsigned DOT_1321 = 2;
  localparam int unsigned DOT_4343 = 3;
  localparam int unsigned DOT_2121 = 4;
  localparam int unsigned N_DOTS   = 5;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned NB_W     = DOT_W + COORD_W + 2;
  localparam int unsigned PT_W     = COORD_W + DIFF_W;
  localparam int unsigned PSUM_W   = PT_W - FRAC_W + 1;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  coord_t in_p1 [3];
  coord_t in_p2 [3];
  coord_t in_p3 [3];
  coord_t in_p4 [3];

  assign in_p1 = '{a_start_x_i, a_start_y_i, a_start_z_i};
  assign in_p2 = '{a_end_x_i, a_end_y_i, a_end_z_i};
  assign in_p3 = '{b_start_x_i, b_start_y_i, b_start_z_i};
  assign in_p4 = '{b_end_x_i, b_end_y_i, b_end_z_i};

  // ---------------- stage 1: differences
  logic  v1_q;
  side_t s1_q;
  diff_t d13_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q.ok    <= 1'b1;
    s1_q.d1343 <= '0;
    s1_q.d4321 <= '0;
    s1_q.d4343 <= '0;
    s1_q.mua   <= '0;
    for (int i = 0; i < 3; i++) begin
      s1_q.p1[i]  <= in_p1[i];
      s1_q.p3[i]  <= in_p3[i];
      s1_q.d21[i] <= DIFF_W'(in_p2[i]) - DIFF_W'(in_p1[i]);
      s1_q.d43[i] <= DIFF_W'(in_p4[i]) - DIFF_W'(in_p3[i]);
      d13_q[i]    <= DIFF_W'(in_p1[i]) - DIFF_W'(in_p3[i]);
    end
  end

  // ---------------- stage 2: component products, short-direction check
  logic                    v2_q;
  side_t                   s2_q;
  side_t                   s2_d;
  logic signed [PROD_W-1:0] prod_q [N_DOTS][3];
  logic [DIFF_W-1:0]       mag21 [3];
  logic [DIFF_W-1:0]       mag43 [3];
  logic                    small21, small43;

  always_comb begin
    small21 = 1'b1;
    small43 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag21[i] = s1_q.d21[i][DIFF_W-1] ? DIFF_W'(-s1_q.d21[i]) : DIFF_W'(s1_q.d21[i]);
      mag43[i] = s1_q.d43[i][DIFF_W-1] ? DIFF_W'(-s1_q.d43[i]) : DIFF_W'(s1_q.d43[i]);
      small21  = small21 && (mag21[i] < DIFF_W'(eps_q));
      small43  = small43 && (mag43[i] < DIFF_W'(eps_q));
    end
    s2_d    = s1_q;
    s2_d.ok = s1_q.ok && !small21 && !small43;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
    for (int i = 0; i < 3; i++) begin
      prod_q[DOT_1343][i] <= $signed(d13_q[i]) * $signed(s1_q.d43[i]);
      prod_q[DOT_4321][i] <= $signed(s1_q.d43[i]) * $signed(s1_q.d21[i]);
      prod_q[DOT_1321][i] <= $signed(d13_q[i]) * $signed(s1_q.d21[i]);
      prod_q[DOT_4343][i] <= $signed(s1_q.d43[i]) * $signed(s1_q.d43[i]);
      prod_q[DOT_2121][i] <= $signed(s1_q.d21[i]) * $signed(s1_q.d21[i]);
    end
  end

  // ---------------- stage 3: dot products, floored to Q36.28
  logic                    v3_q;
  side_t                   s3_q;
  side_t                   s3_d;
  dot_t                    dot_q [N_DOTS];
  logic signed [SUM_W-1:0] dsum  [N_DOTS];

  always_comb begin
    for (int j = 0; j < N_DOTS; j++) begin
      dsum[j] = SUM_W'(prod_q[j][0]) + SUM_W'(prod_q[j][1]) + SUM_W'(prod_q[j][2]);
    end
    s3_d       = s2_q;
    s3_d.d1343 = dsum[DOT_1343][SUM_W-1:4];
    s3_d.d4321 = dsum[DOT_4321][SUM_W-1:4];
    s3_d.d4343 = dsum[DOT_4343][SUM_W-1:4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
    for (int j = 0; j < N_DOTS; j++) begin
      dot_q[j] <= dsum[j][SUM_W-1:4];
    end
  end

  // ---------------- stages 4-5: wide products
  logic                    v4_q, v5_q;
  side_t                   s4_q, s5_q;
  side_t                   s4_d;
  logic signed [WIDE_W-1:0] p_den1, p_den2, p_num1, p_num2;

  llcp_mul64 u_mul_den1 (.clk_i, .a_i(dot_q[DOT_2121]), .b_i(dot_q[DOT_4343]), .p_o(p_den1));
  llcp_mul64 u_mul_den2 (.clk_i, .a_i(dot_q[DOT_4321]), .b_i(dot_q[DOT_4321]), .p_o(p_den2));
  llcp_mul64 u_mul_num1 (.clk_i, .a_i(dot_q[DOT_1343]), .b_i(dot_q[DOT_4321]), .p_o(p_num1));
  llcp_mul64 u_mul_num2 (.clk_i, .a_i(dot_q[DOT_1321]), .b_i(dot_q[DOT_4343]), .p_o(p_num2));

  always_comb begin
    s4_d    = s3_q;
    s4_d.ok = s3_q.ok && (dot_q[DOT_4343] != '0) && (dot_q[DOT_2121] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q <= s4_d;
    s5_q <= s4_q;
  end

  // ---------------- stage 6: numerator and denominator
  logic                     v6_q;
  side_t                    s6_q;
  logic signed [WIDE_W-1:0] numer_q, denom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_q    <= s5_q;
    numer_q <= p_num1 - p_num2;
    denom_q <= p_den1 - p_den2;
  end

  // parallel-line check rides into the first divider
  logic [WIDE_W-1:0] den_mag;
  side_t             side_a_in;

  always_comb begin
    den_mag      = denom_q[WIDE_W-1] ? WIDE_W'(-denom_q) : WIDE_W'(denom_q);
    side_a_in    = s6_q;
    side_a_in.ok = s6_q.ok && (denom_q != '0) &&
                   !(den_mag < WIDE_W'({eps_q, {EPS_SHIFT{1'b0}}}));
  end

  logic   va_out;
  coord_t quot_a;
  side_t  side_a;

  llcp_div u_div_a (
    .clk_i,
    .rst_ni,
    .valid_i (v6_q),
    .num_i   ({numer_q, {FRAC_W{1'b0}}}),
    .den_i   (denom_q),
    .side_i  (side_a_in),
    .valid_o (va_out),
    .quot_o  (quot_a),
    .side_o  (side_a)
  );

  // ---------------- second numerator: d1343 * 2^16 + d4321 * mua
  logic                       vn1_q, vn2_q;
  side_t                      sn1_q, sn2_q;
  side_t                      sn1_d;
  logic signed [DOT_W-1:0]    pph_q;
  logic signed [DOT_W:0]      ppl_q;
  logic signed [NB_W-1:0]     nb_q;

  always_comb begin
    sn1_d     = side_a;
    sn1_d.mua = quot_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn1_q <= 1'b0;
      vn2_q <= 1'b0;
    end else begin
      vn1_q <= va_out;
      vn2_q <= vn1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sn1_q     <= sn1_d;
    pph_q     <= $signed(side_a.d4321[DOT_W-1:COORD_W]) * $signed(quot_a);
    ppl_q     <= $signed({1'b0, side_a.d4321[COORD_W-1:0]}) * $signed(quot_a);
    sn2_q     <= sn1_q;
    nb_q      <= (NB_W'(pph_q) <<< COORD_W) + NB_W'(ppl_q) +
                 (NB_W'($signed(sn1_q.d1343)) <<< FRAC_W);
  end

  logic   vb_out;
  coord_t quot_b;
  side_t  side_b;

  llcp_div u_div_b (
    .clk_i,
    .rst_ni,
    .valid_i (vn2_q),
    .num_i   (NUM_W'(nb_q)),
    .den_i   (WIDE_W'($signed(sn2_q.d4343))),
    .side_i  (sn2_q),
    .valid_o (vb_out),
    .quot_o  (quot_b),
    .side_o  (side_b)
  );

  // ---------------- point products
  logic                   vp1_q;
  side_t                  sp1_q;
  coord_t                 mub_q;
  logic signed [PT_W-1:0] pa_q [3];
  logic signed [PT_W-1:0] pb_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q <= 1'b0;
    end else begin
      vp1_q <= vb_out;
    end
  end

  always_ff @(posedge clk_i) begin
    sp1_q <= side_b;
    mub_q <= quot_b;
    for (int i = 0; i < 3; i++) begin
      pa_q[i] <= $signed(side_b.mua) * $signed(side_b.d21[i]);
      pb_q[i] <= $signed(quot_b) * $signed(side_b.d43[i]);
    end
  end

  // ---------------- add start point, saturate, zero out on failure
  logic signed [PSUM_W-1:0] suma [3];
  logic signed [PSUM_W-1:0] sumb [3];
  coord_t                   pta  [3];
  coord_t                   ptb  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      suma[i] = PSUM_W'($signed(sp1_q.p1[i])) + PSUM_W'(pa_q[i] >>> FRAC_W);
      sumb[i] = PSUM_W'($signed(sp1_q.p3[i])) + PSUM_W'(pb_q[i] >>> FRAC_W);
      if (suma[i] > PSUM_W'(SAT_MAX)) begin
        pta[i] = SAT_MAX;
      end else if (suma[i] < PSUM_W'(SAT_MIN)) begin
        pta[i] = SAT_MIN;
      end else begin
        pta[i] = suma[i][COORD_W-1:0];
      end
      if (sumb[i] > PSUM_W'(SAT_MAX)) begin
        ptb[i] = SAT_MAX;
      end else if (sumb[i] < PSUM_W'(SAT_MIN)) begin
        ptb[i] = SAT_MIN;
      end else begin
        ptb[i] = sumb[i][COORD_W-1:0];
      end
    end
  end

  logic   strobe_q;
  logic   ok_q;
  coord_t param_a_q, param_b_q;
  coord_t near_a_q [3];
  coord_t near_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= vp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q      <= sp1_q.ok;
    param_a_q <= sp1_q.ok ? sp1_q.mua : '0;
    param_b_q <= sp1_q.ok ? mub_q : '0;
    for (int i = 0; i < 3; i++) begin
      near_a_q[i] <= sp1_q.ok ? pta[i] : '0;
      near_b_q[i] <= sp1_q.ok ? ptb[i] : '0;
    end
  end

  assign strobe_o      = strobe_q;
  assign solution_ok_o = ok_q;
  assign param_a_o     = param_a_q;
  assign param_b_o     = param_b_q;
  assign near_a_x_o    = near_a_q[0];
  assign near_a_y_o    = near_a_q[1];
  assign near_a_z_o    = near_a_q[2];
  assign near_b_x_o    = near_b_q[0];
  assign near_b_y_o    = near_b_q[1];
  assign near_b_z_o    = near_b_q[2];

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !solution_ok_o |-> param_a_o == '0 && param_b_o == '0 &&
      near_a_x_o == '0 && near_b_z_o == '0)
    else $error("failed result carries nonzero fields");

endmodule
`default_nettype wire
